// ----- src/pnf_pkg.sv -----
// pnf_pkg: shared types and constants for the printf number formatter
// no dependencies
package pnf_pkg;

   localparam logic [7:0] CHAR_PERCENT = 8'h25;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_MINUS   = 8'h2D;
   localparam logic [7:0] SPEC_U       = 8'h75;
   localparam logic [7:0] SPEC_D_LO    = 8'h64;
   localparam logic [7:0] SPEC_D_HI    = 8'h44;
   localparam logic [7:0] SPEC_X       = 8'h78;
   localparam logic [7:0] SPEC_B       = 8'h62;
   localparam logic [7:0] SPEC_C       = 8'h63;
   localparam int IDX_W = 7;

   typedef enum logic [2:0] {
      ST_IDLE, ST_DEC, ST_EMIT
   } state_type;

   // kind of digit string that follows the prefix
   typedef enum logic [1:0] {
      BODY_NONE, BODY_HEX, BODY_BIN, BODY_DEC
   } body_type;

   // input transfer payload
   typedef struct packed {
      logic [7:0]  format_byte;
      logic [63:0] argument_value;
   } fmt_req_type;

   // result transfer payload
   typedef struct packed {
      logic [7:0] first_char;
      logic [7:0] second_char;
      logic [1:0] char_count;
      logic       last_of_run;
   } fmt_rsp_type;

   // controller to datapath
   typedef struct packed {
      logic load;      // accept input and decode
      logic dec_step;  // one shift-and-add step of decimal conversion
      logic dec_done;  // latch the decimal digit count
      logic emit;      // output transfer taken, advance read pointer
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic need_dec;  // decimal conversion requested
      logic has_out;   // at least one character pending
      logic dec_last;  // final conversion step
      logic out_last;  // current item is last
   } status_type;

   function automatic logic [7:0] hex_char(input logic [3:0] v);
      hex_char = (v < 4'd10) ? (CHAR_ZERO + {4'd0, v}) : (8'h37 + {4'd0, v});
   endfunction

endpackage

// ----- src/pnf_if.sv -----
// pnf_if: valid/ready channel carrying a payload of generic type
// depends on nothing
interface pnf_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ----- src/pnf_ctrl.sv -----
// pnf_ctrl: sequencing state machine of the formatter
// depends on pnf_pkg
module pnf_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  pnf_pkg::status_type status,
   output pnf_pkg::cmd_type    cmd
);
   import pnf_pkg::*;

   state_type state_ff, state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_DEC;
         end
         ST_DEC: begin
            if (!status.need_dec || status.dec_last) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!status.has_out) state_in = ST_IDLE;
            else if (rsp_ready && status.out_last) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load = req_valid;
         end
         ST_DEC: begin
            cmd.dec_step = status.need_dec;
            cmd.dec_done = status.need_dec && status.dec_last;
         end
         ST_EMIT: begin
            rsp_valid = status.has_out;
            cmd.emit = status.has_out && rsp_ready;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end
endmodule

// ----- src/pnf_dp.sv -----
// pnf_dp: decode, double-dabble decimal unit and character selection
// depends on pnf_pkg
module pnf_dp (
   input  logic               clock,
   input  logic               reset,
   input  logic [7:0]         format_byte,
   input  logic [63:0]        argument_value,
   input  pnf_pkg::cmd_type    cmd,
   output pnf_pkg::status_type status,
   output logic [7:0]         first_char,
   output logic [7:0]         second_char,
   output logic [1:0]         char_count,
   output logic               last_of_run
);
   import pnf_pkg::*;

   logic              pend_ff;
   logic [7:0]        pre0_ff, pre1_ff;
   logic [1:0]        plen_ff;
   body_type          body_ff;
   logic [IDX_W-1:0]  ndig_ff, len_ff, rd_ff;
   logic [63:0]       val_ff;
   logic [79:0]       bcd_ff;
   logic [6:0]        cnt_ff;
   logic              need_ff;

   // character at a position: prefix first, then digits most significant first
   function automatic logic [7:0] char_at(
      input logic [IDX_W-1:0] pos,
      input logic [1:0]       plen,
      input logic [7:0]       pre0,
      input logic [7:0]       pre1,
      input body_type         body,
      input logic [IDX_W-1:0] ndig,
      input logic [63:0]      val,
      input logic [79:0]      bcd
   );
      logic [IDX_W-1:0] d;
      d = ndig - 7'd1 - (pos - {5'd0, plen});
      char_at = 8'd0;
      if (pos < {5'd0, plen}) char_at = (pos == 7'd0) ? pre0 : pre1;
      else begin
         case (body)
            BODY_HEX: char_at = hex_char(val[{d[3:0], 2'b00} +: 4]);
            BODY_BIN: char_at = CHAR_ZERO + {7'd0, val[d[5:0]]};
            BODY_DEC: char_at = CHAR_ZERO + {4'd0, bcd[{d[4:0], 2'b00} +: 4]};
            default: ;
         endcase
      end
   endfunction

   // decode of the accepted byte into prefix and digit string
   logic [7:0]        ld_pre0, ld_pre1;
   logic [1:0]        ld_plen;
   body_type          ld_body;
   logic [IDX_W-1:0]  ld_ndig, ld_len;
   logic              ld_dec, ld_pend;
   logic [63:0]       ld_val;
   logic [31:0]       lo;
   logic [3:0]        nbytes;
   logic [6:0]        nbits;
   always_comb begin
      ld_pre0 = format_byte;
      ld_pre1 = 8'd0;
      ld_plen = 2'd0;
      ld_body = BODY_NONE;
      ld_ndig = '0;
      ld_dec = 1'b0;
      ld_pend = 1'b0;
      ld_val = argument_value;
      lo = argument_value[31:0];
      nbytes = (argument_value[63:32] != 0) ? 4'd8 :
               (argument_value[31:16] != 0) ? 4'd4 :
               (argument_value[15:8] != 0) ? 4'd2 : 4'd1;
      nbits = {nbytes, 3'd0};
      if (!pend_ff) begin
         if (format_byte == CHAR_PERCENT) ld_pend = 1'b1;
         else ld_plen = 2'd1;
      end else begin
         case (format_byte)
            CHAR_PERCENT: ld_plen = 2'd1;
            SPEC_C: begin
               ld_pre0 = argument_value[7:0];
               ld_plen = 2'd1;
            end
            SPEC_U: begin
               ld_dec = 1'b1;
               ld_body = BODY_DEC;
            end
            SPEC_D_LO: begin
               ld_dec = 1'b1;
               ld_body = BODY_DEC;
               ld_val = {32'd0, lo};
               if (lo[31]) begin
                  ld_pre0 = CHAR_MINUS;
                  ld_plen = 2'd1;
                  ld_val = {32'd0, 32'd0 - lo};
               end
            end
            SPEC_D_HI: begin
               ld_dec = 1'b1;
               ld_body = BODY_DEC;
               if (argument_value[63]) begin
                  ld_pre0 = CHAR_MINUS;
                  ld_plen = 2'd1;
                  ld_val = 64'd0 - argument_value;
               end
            end
            SPEC_X: begin
               ld_pre0 = CHAR_ZERO;
               ld_pre1 = SPEC_X;
               ld_plen = 2'd2;
               ld_body = BODY_HEX;
               ld_ndig = {2'd0, nbytes, 1'b0};
            end
            SPEC_B: begin
               ld_pre0 = CHAR_ZERO;
               ld_pre1 = SPEC_B;
               ld_plen = 2'd2;
               ld_body = BODY_BIN;
               ld_ndig = nbits;
            end
            default: ;
         endcase
      end
      ld_len = {5'd0, ld_plen} + ld_ndig;
   end

   // one double-dabble step: add 3 to digits >= 5, then shift
   logic [79:0] bcd_adj;
   always_comb begin
      for (int i = 0; i < 20; i++)
         bcd_adj[4 * i +: 4] = (bcd_ff[4 * i +: 4] >= 4'd5) ?
                               bcd_ff[4 * i +: 4] + 4'd3 : bcd_ff[4 * i +: 4];
   end

   // number of decimal digits in the final bcd value, at least one
   logic [4:0] ndig;
   always_comb begin
      ndig = 5'd1;
      for (int i = 1; i < 20; i++)
         if (bcd_ff[4 * i +: 4] != 4'd0) ndig = 5'(i + 1);
   end

   // operand, digit string and pointers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         pre0_ff <= ld_pre0;
         pre1_ff <= ld_pre1;
         plen_ff <= ld_plen;
         body_ff <= ld_body;
         ndig_ff <= ld_ndig;
         len_ff <= ld_len;
         rd_ff <= '0;
         need_ff <= ld_dec;
         val_ff <= ld_val;
         bcd_ff <= '0;
         cnt_ff <= '0;
      end else if (cmd.dec_step) begin
         if (cmd.dec_done) begin
            ndig_ff <= {2'd0, ndig};
            len_ff <= len_ff + {2'd0, ndig};
            need_ff <= 1'b0;
         end else begin
            {bcd_ff, val_ff} <= {bcd_adj, val_ff} << 1;
            cnt_ff <= cnt_ff + 7'd1;
         end
      end else if (cmd.emit) begin
         rd_ff <= rd_ff + 7'd2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) pend_ff <= 1'b0;
      else if (cmd.load) pend_ff <= ld_pend;
   end

   // characters left to send
   logic [IDX_W-1:0] rem;
   assign rem = len_ff - rd_ff;

   always_comb begin
      status.need_dec = need_ff;
      status.dec_last = (cnt_ff == 7'd64);
      status.has_out = (rd_ff < len_ff);
      status.out_last = (rem <= 7'd2);
   end

   // result item from the read pointer
   assign first_char = char_at(rd_ff, plen_ff, pre0_ff, pre1_ff, body_ff, ndig_ff,
                               val_ff, bcd_ff);
   assign second_char = (rem >= 7'd2) ?
      char_at(rd_ff + 7'd1, plen_ff, pre0_ff, pre1_ff, body_ff, ndig_ff, val_ff, bcd_ff) :
      8'd0;
   assign char_count = (rem >= 7'd2) ? 2'd2 : 2'd1;
   assign last_of_run = status.out_last;
endmodule

// ----- src/printf_number_formatter.sv -----
// printf_number_formatter: decimal specifiers run 64 shift-and-add steps and one
// digit count in the datapath, other bytes pass once through the conversion state;
// then one result transfer per cycle while rsp.ready is high, until the run is drained.
// One item at a time; throughput is set by conversion and drain of results.
// Synchronous reset clears the pending-percent flag and the controller.
module printf_number_formatter (
   input logic clock,
   input logic reset,
   pnf_if.sink   req,
   pnf_if.source rsp
);
   import pnf_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic [7:0] first_char, second_char;
   logic [1:0] char_count;
   logic       last_of_run;

   pnf_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req.valid), .req_ready(req.ready),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
      .status(status), .cmd(cmd)
   );

   pnf_dp u_dp (
      .clock(clock), .reset(reset),
      .format_byte(req.data.format_byte),
      .argument_value(req.data.argument_value),
      .cmd(cmd), .status(status),
      .first_char(first_char),
      .second_char(second_char),
      .char_count(char_count),
      .last_of_run(last_of_run)
   );

   // result payload
   assign rsp.data = fmt_rsp_type'{first_char: first_char, second_char: second_char,
                                   char_count: char_count, last_of_run: last_of_run};

`ifndef SYNTHESIS
   // never accept and deliver at once
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(req.ready && rsp.valid)) else $error("accept during output");
   // a result count is 1 or 2
   a_cnt: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.data.char_count == 2'd1 || rsp.data.char_count == 2'd2))
      else $error("bad char count");
   // after a last transfer the block is ready again
   a_last: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.ready && rsp.data.last_of_run) |=> req.ready)
      else $error("not ready after last");
`endif
endmodule
